/* design/sqp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sqp_pkg;

  localparam int ANGLE_W = 32;
  localparam int OUT_W   = 18;

  localparam int ANGLE_FRAC_DEF = 24;
  localparam int OUT_FRAC_DEF   = 16;

  // internal working fraction bits
  localparam int QF = 30;
  // width of Q30 working values (t, t^2, polynomial terms)
  localparam int VW = 34;
  // wrap width for the reduced angle in Q40
  localparam int TW = 44;
  // pipeline depth
  localparam int NSTAGE = 9;

  typedef logic signed [VW-1:0]   val_t;
  typedef logic signed [2*VW-1:0] prod_t;
  typedef logic signed [TW-1:0]   red_t;

  // 2/pi in Q0.32, kept positive in a signed 64-bit container
  localparam logic signed [63:0] TWO_OVER_PI_Q32 = 64'sh0000_0000_A2F9_836E;
  // pi/2 in Q40
  localparam red_t HALF_PI_Q40 = 44'sh192_1FB5_4443;

  localparam val_t SC0 = 34'sd1073709612;
  localparam val_t SC1 = 34'sd178198193;
  localparam val_t SC2 = 34'sd8149700;
  localparam val_t CC0 = 34'sd1073698874;
  localparam val_t CC1 = 34'sd536709851;
  localparam val_t CC2 = 34'sd39288213;

  localparam logic signed [VW:0] OUT_MAX = 35'sd131071;
  localparam logic signed [VW:0] OUT_MIN = -35'sd131072;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

endpackage

`default_nettype wire

/* design/sincos_poly_quadrant_core.sv */
// Sine and cosine of a Q8.24 angle, both results per item, Q2.16 saturated.
// Nine register stages; throughput one item per cycle while the output is not
// stalled, as each register stage can take a new item every cycle.
// Each stage holds while the one after it is full and stalled; bubbles close up.
// Reset (rst_n low, synchronous) empties the pipeline; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module sincos_poly_quadrant_core #(
  parameter int ANGLE_FRAC_BITS = sqp_pkg::ANGLE_FRAC_DEF,
  parameter int OUT_FRAC_BITS   = sqp_pkg::OUT_FRAC_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  signed [sqp_pkg::ANGLE_W-1:0]   in_angle,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [sqp_pkg::OUT_W-1:0]     out_sine_out,
  output logic signed [sqp_pkg::OUT_W-1:0]     out_cosine_out
);

  localparam int NS   = sqp_pkg::NSTAGE;
  localparam int VW   = sqp_pkg::VW;
  localparam int TW   = sqp_pkg::TW;
  localparam int QF   = sqp_pkg::QF;
  localparam int QW   = sqp_pkg::ANGLE_W - ANGLE_FRAC_BITS;
  localparam int ASH  = 40 - ANGLE_FRAC_BITS;
  localparam int SH   = QF - OUT_FRAC_BITS;
  localparam logic signed [VW:0] HALF =
    (SH == 0) ? '0 : (VW+1)'(64'sd1 <<< (SH - 1));

  // ---------------- stage control ----------------
  logic [NS:1] v_r, v_nxt;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v_r[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[1]) v_nxt[1] = in_valid;
    for (int k = 2; k <= NS; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[NS];

  // ---------------- stage 1: capture angle ----------------
  logic signed [sqp_pkg::ANGLE_W-1:0] a1_r;

  always_ff @(posedge clk) begin
    if (en[1]) a1_r <= in_angle;
  end

  // ---------------- stage 2: angle * 2/pi ----------------
  logic signed [63:0] pq2_r, pq2_nxt;
  logic signed [sqp_pkg::ANGLE_W-1:0] a2_r;

  assign pq2_nxt = 64'(64'(a1_r) * sqp_pkg::TWO_OVER_PI_Q32);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pq2_r <= pq2_nxt;
      a2_r  <= a1_r;
    end
  end

  // ---------------- stage 3: q * pi/2 (mod 2^TW) ----------------
  logic signed [QW-1:0] q3;
  sqp_pkg::red_t q3_ext;
  sqp_pkg::red_t hq3_r, hq3_nxt;
  sqp_pkg::red_t ash3_r, ash3_nxt;
  logic [1:0] quad3_r;

  assign q3       = pq2_r[63 -: QW];
  assign q3_ext   = TW'(q3);
  assign hq3_nxt  = TW'(q3_ext * sqp_pkg::HALF_PI_Q40);
  assign ash3_nxt = TW'(a2_r) <<< ASH;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hq3_r   <= hq3_nxt;
      ash3_r  <= ash3_nxt;
      quad3_r <= q3[1:0];
    end
  end

  // ---------------- stage 4: reduced angle t in Q30 ----------------
  sqp_pkg::red_t t40;
  sqp_pkg::val_t t4_r, t4_nxt;
  logic [1:0] quad4_r;

  assign t40    = ash3_r - hq3_r;
  // the true t lies well inside 32 bits signed
  assign t4_nxt = VW'($signed(t40[10 +: 32]));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      t4_r    <= t4_nxt;
      quad4_r <= quad3_r;
    end
  end

  // ---------------- stage 5: t * t ----------------
  sqp_pkg::prod_t tt5_r, tt5_nxt;
  sqp_pkg::val_t t5_r;
  logic [1:0] quad5_r;

  assign tt5_nxt = t4_r * t4_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      tt5_r   <= tt5_nxt;
      t5_r    <= t4_r;
      quad5_r <= quad4_r;
    end
  end

  // ---------------- stage 6: t2 * innermost coefficients ----------------
  sqp_pkg::val_t t2_6;
  sqp_pkg::val_t t2_6_r, t6_r;
  sqp_pkg::prod_t ms6_r, mc6_r, ms6_nxt, mc6_nxt;
  logic [1:0] quad6_r;

  assign t2_6    = $signed(tt5_r[QF +: VW]);
  assign ms6_nxt = t2_6 * sqp_pkg::SC2;
  assign mc6_nxt = t2_6 * sqp_pkg::CC2;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      ms6_r   <= ms6_nxt;
      mc6_r   <= mc6_nxt;
      t2_6_r  <= t2_6;
      t6_r    <= t5_r;
      quad6_r <= quad5_r;
    end
  end

  // ---------------- stage 7: t2 * (C1 - t2*C2) ----------------
  sqp_pkg::val_t u1_7, w1_7;
  sqp_pkg::prod_t ps7_r, pc7_r, ps7_nxt, pc7_nxt;
  sqp_pkg::val_t t7_r;
  logic [1:0] quad7_r;

  assign u1_7    = sqp_pkg::SC1 - $signed(ms6_r[QF +: VW]);
  assign w1_7    = sqp_pkg::CC1 - $signed(mc6_r[QF +: VW]);
  assign ps7_nxt = t2_6_r * u1_7;
  assign pc7_nxt = t2_6_r * w1_7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      ps7_r   <= ps7_nxt;
      pc7_r   <= pc7_nxt;
      t7_r    <= t6_r;
      quad7_r <= quad6_r;
    end
  end

  // ---------------- stage 8: sine product, cosine sum ----------------
  sqp_pkg::val_t u2_8;
  sqp_pkg::prod_t ps8_r, ps8_nxt;
  sqp_pkg::val_t c8_r, c8_nxt;
  logic [1:0] quad8_r;

  assign u2_8    = sqp_pkg::SC0 - $signed(ps7_r[QF +: VW]);
  assign ps8_nxt = t7_r * u2_8;
  assign c8_nxt  = sqp_pkg::CC0 - $signed(pc7_r[QF +: VW]);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      ps8_r   <= ps8_nxt;
      c8_r    <= c8_nxt;
      quad8_r <= quad7_r;
    end
  end

  // ---------------- stage 9: quadrant swap, round, saturate ----------------
  function automatic logic signed [sqp_pkg::OUT_W-1:0] to_out(input sqp_pkg::val_t v);
    logic signed [VW:0] sum;
    logic signed [VW:0] r;
    sum = (VW+1)'(v) + HALF;
    r   = sum >>> SH;
    if (r > sqp_pkg::OUT_MAX) begin
      to_out = sqp_pkg::OUT_W'(sqp_pkg::OUT_MAX);
    end else if (r < sqp_pkg::OUT_MIN) begin
      to_out = sqp_pkg::OUT_W'(sqp_pkg::OUT_MIN);
    end else begin
      to_out = r[sqp_pkg::OUT_W-1:0];
    end
  endfunction

  sqp_pkg::val_t s9, so9, co9;
  logic signed [sqp_pkg::OUT_W-1:0] sine_r, cosine_r, sine_nxt, cosine_nxt;

  assign s9 = $signed(ps8_r[QF +: VW]);

  always_comb begin
    case (quad8_r)
      sqp_pkg::QUAD_0: begin so9 = s9;    co9 = c8_r;  end
      sqp_pkg::QUAD_1: begin so9 = c8_r;  co9 = -s9;   end
      sqp_pkg::QUAD_2: begin so9 = -s9;   co9 = -c8_r; end
      sqp_pkg::QUAD_3: begin so9 = -c8_r; co9 = s9;    end
      default:         begin so9 = s9;    co9 = c8_r;  end
    endcase
  end

  assign sine_nxt   = to_out(so9);
  assign cosine_nxt = to_out(co9);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      sine_r   <= sine_nxt;
      cosine_r <= cosine_nxt;
    end
  end

  assign out_sine_out   = sine_r;
  assign out_cosine_out = cosine_r;

  // ---------------- checks ----------------
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[1])
    else $error("accepted item missing from first stage");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] && !en[NS] |=> v_r[NS-1] && v_r[NS])
    else $error("item lost while the output stalls");

endmodule

`default_nettype wire
